### design/nvoc_pkg.sv
// ----------------------------------------------------------------------------
// nvoc_pkg
// Shared types and constants of the virtual channel output port.
// ----------------------------------------------------------------------------
package nvoc_pkg;

  localparam int PORT_BITS   = 3;
  localparam int VC_BITS     = 2;
  localparam int KIND_BITS   = 2;
  localparam int DATA_W      = 32;
  localparam int CREDIT_BITS = 4;
  localparam int MASK_BITS   = 5;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // register index from paddr[2]
  localparam logic REG_LOCAL_MODE = 1'b0;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_ARRIVE = 1'b1;

  typedef struct packed {
    logic                   action;
    logic [PORT_BITS-1:0]   in_port;
    logic [VC_BITS-1:0]     flit_vc;
    logic [KIND_BITS-1:0]   flit_kind;
    logic [DATA_W-1:0]      flit_data;
    logic [CREDIT_BITS-1:0] credit_free;
  } in_item_t;

  typedef struct packed {
    logic                 out_valid;
    logic [VC_BITS-1:0]   out_vc;
    logic [KIND_BITS-1:0] out_kind;
    logic [DATA_W-1:0]    out_data;
    logic [MASK_BITS-1:0] ready_mask;
  } out_item_t;

endpackage

### design/nvoc_cfg_regs.sv
// ----------------------------------------------------------------------------
// nvoc_cfg_regs
// Configuration register file behind the register access port.
// ----------------------------------------------------------------------------
module nvoc_cfg_regs
  import nvoc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  local_mode
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_mode <= 1'b0;
    end else if (wr_en && paddr[2] == REG_LOCAL_MODE) begin
      local_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LOCAL_MODE) begin
      prdata[0] = local_mode;
    end
  end

endmodule

### design/nvoc_core.sv
// ----------------------------------------------------------------------------
// nvoc_core
// Port and virtual channel flit registers with the per-item update logic.
// ----------------------------------------------------------------------------
module nvoc_core
  import nvoc_pkg::*;
#(
  parameter int NUM_IN    = 5,
  parameter int NUM_VC    = 4,
  parameter int DATA_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  input  logic      local_mode,
  output out_item_t result
);

  localparam int KEEP_BITS = (DATA_BITS < DATA_W) ? DATA_BITS : DATA_W;
  localparam int IW        = (NUM_IN > 1) ? $clog2(NUM_IN) : 1;
  localparam int VW        = (NUM_VC > 1) ? $clog2(NUM_VC) : 1;

  typedef struct packed {
    logic [VC_BITS-1:0]   vc;
    logic [KIND_BITS-1:0] kind;
    logic [KEEP_BITS-1:0] data;
  } flit_t;

  logic [NUM_VC-1:0] vc_busy;
  flit_t             vc_store [NUM_VC];
  logic [NUM_IN-1:0] port_busy;
  flit_t             port_store [NUM_IN];
  logic [VW-1:0]     vc_turn;
  logic [NUM_IN-1:0] port_ready;

  logic [VW-1:0]     vc_turn_next;
  logic [NUM_VC-1:0] vc_busy_next;
  logic [NUM_IN-1:0] port_busy_next;
  logic [NUM_IN-1:0] port_ready_next;
  logic [NUM_VC-1:0] vc_we;
  flit_t             vc_wd [NUM_VC];
  logic              port_we;
  logic [IW-1:0]     pi;
  logic [VW-1:0]     fi;
  logic [VW-1:0]     vi;
  flit_t             arr;
  flit_t             head;
  logic              send_ok;
  out_item_t         res;

  always_comb begin
    vc_turn_next    = vc_turn;
    vc_busy_next    = vc_busy;
    port_busy_next  = port_busy;
    port_ready_next = port_ready;
    vc_we           = '0;
    port_we         = 1'b0;
    res             = '0;
    pi              = IW'(item.in_port);
    fi              = VW'(item.flit_vc);
    vi              = '0;
    arr.vc          = item.flit_vc;
    arr.kind        = item.flit_kind;
    arr.data        = KEEP_BITS'(item.flit_data);
    for (int v = 0; v < NUM_VC; v++) begin
      vc_wd[v] = arr;
    end

    if (vc_turn == VW'(NUM_VC - 1)) begin
      vc_turn_next = '0;
    end else begin
      vc_turn_next = vc_turn + VW'(1);
    end
    head    = vc_store[vc_turn_next];
    send_ok = local_mode || item.credit_free[head.vc];

    if (item.action == ACT_TICK) begin
      if (vc_busy[vc_turn_next] && send_ok) begin
        res.out_valid                = 1'b1;
        res.out_vc                   = head.vc;
        res.out_kind                 = head.kind;
        res.out_data                 = DATA_W'(head.data);
        vc_busy_next[vc_turn_next]   = 1'b0;
      end
      // waiting ports drain in order, lowest port first
      for (int p = 0; p < NUM_IN; p++) begin
        if (port_busy[p]) begin
          vi = VW'(port_store[p].vc);
          if ((5'(port_store[p].vc) < 5'(NUM_VC)) && !vc_busy_next[vi]) begin
            vc_busy_next[vi]   = 1'b1;
            vc_we[vi]          = 1'b1;
            vc_wd[vi]          = port_store[p];
            port_busy_next[p]  = 1'b0;
            port_ready_next[p] = 1'b1;
          end else begin
            port_ready_next[p] = 1'b0;
          end
        end
      end
    end else if ((4'(item.in_port) < 4'(NUM_IN)) &&
                 (5'(item.flit_vc) < 5'(NUM_VC))) begin
      port_we = 1'b1;
      if (!vc_busy[fi]) begin
        vc_busy_next[fi]    = 1'b1;
        vc_we[fi]           = 1'b1;
        vc_wd[fi]           = arr;
        port_busy_next[pi]  = 1'b0;
        port_ready_next[pi] = 1'b1;
      end else begin
        port_busy_next[pi]  = 1'b1;
        port_ready_next[pi] = 1'b0;
      end
    end

    res.ready_mask = MASK_BITS'(port_ready_next);
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc_busy    <= '0;
      port_busy  <= '0;
      vc_turn    <= '0;
      port_ready <= '1;
    end else if (fire) begin
      vc_busy    <= vc_busy_next;
      port_busy  <= port_busy_next;
      if (item.action == ACT_TICK) begin
        vc_turn <= vc_turn_next;
      end
      port_ready <= port_ready_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int v = 0; v < NUM_VC; v++) begin
        if (vc_we[v]) begin
          vc_store[v] <= vc_wd[v];
        end
      end
      if (port_we) begin
        port_store[pi] <= arr;
      end
    end
  end

endmodule

### design/noc_vc_output_channel.sv
// result path: an accepted item waits in the input register, its result in the result register
// throughput: one item per cycle unless m_tready stalls; the port and vc flit registers
//   update in the cycle the item leaves the input register; the next item sees them at once
// reset: synchronous active-high rst clears all vc and port busy flags, the round-robin
//   pointer and local_mode, and sets every port ready; flit payload registers are not reset
// ----------------------------------------------------------------------------
// noc_vc_output_channel
// Router output port with per-port input registers, per-vc flit registers and
// round-robin departure, credit-checked unless local_mode is set.
// ----------------------------------------------------------------------------
module noc_vc_output_channel
  import nvoc_pkg::*;
#(
  parameter int NUM_IN    = 5,
  parameter int NUM_VC    = 4,
  parameter int DATA_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // in_port, flit_vc, flit_kind, flit_data, credit_free, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // action
  input  logic [0:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // out_vc, out_kind, out_data, ready_mask, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // out_valid
  output logic [0:0]             m_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  logic      local_mode;
  logic      s1_valid;
  in_item_t  s1_item;
  in_item_t  in_item;
  logic      advance;
  out_item_t result;
  out_item_t out_item;

  nvoc_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .local_mode (local_mode)
  );

  always_comb begin
    in_item.action      = s_tuser[0];
    in_item.in_port     = s_tdata[2:0];
    in_item.flit_vc     = s_tdata[4:3];
    in_item.flit_kind   = s_tdata[6:5];
    in_item.flit_data   = s_tdata[38:7];
    in_item.credit_free = s_tdata[42:39];
  end

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item <= in_item;
    end
  end

  nvoc_core #(
    .NUM_IN    (NUM_IN),
    .NUM_VC    (NUM_VC),
    .DATA_BITS (DATA_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .item       (s1_item),
    .local_mode (local_mode),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  always_comb begin
    m_tdata        = '0;
    m_tdata[1:0]   = out_item.out_vc;
    m_tdata[3:2]   = out_item.out_kind;
    m_tdata[35:4]  = out_item.out_data;
    m_tdata[40:36] = out_item.ready_mask;
    m_tuser[0]     = out_item.out_valid;
  end

`ifndef SYNTH
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid && !m_tready))
    else $error("input stalled without a full pipeline");

  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("pending item dropped from input register");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed or dropped");
`endif

endmodule

### test/tb_noc_vc_output_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_noc_vc_output_channel
// Streams flit arrivals and vc ticks into the output port and checks every
// result item against a cycle-free model of the port and vc registers, the
// round-robin pointer and the credit check. The ejection mode is switched
// between phases while the port is idle. Both stream sides idle in random bursts, but not in the last phase.
// ----------------------------------------------------------------------------
module tb_noc_vc_output_channel;
  import nvoc_pkg::*;

  localparam int NUM_IN    = 5;
  localparam int NUM_VC    = 4;
  localparam int DATA_BITS = 32;
  localparam int WATCHDOG  = 2000;
  localparam logic [APB_ADDR_W-1:0] ADDR_LOCAL_MODE = {REG_LOCAL_MODE, 2'b00};

  typedef struct packed {
    logic [VC_BITS-1:0]   vc;
    logic [KIND_BITS-1:0] kind;
    logic [DATA_W-1:0]    data;
  } held_flit_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0]             m_tuser;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  noc_vc_output_channel #(
    .NUM_IN(NUM_IN),
    .NUM_VC(NUM_VC),
    .DATA_BITS(DATA_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  in_item_t   port_items[$];
  out_item_t  egress_expect[$];
  in_item_t   cur_item;
  bit         idle_on = 1'b1;
  int         err_cnt = 0;
  int         src_gap = 0;
  int         sink_stall = 0;
  int         quiet_cycles = 0;

  // port model
  logic [NUM_VC-1:0] vc_full;
  held_flit_t        vc_flit [NUM_VC];
  logic [NUM_IN-1:0] port_full;
  held_flit_t        port_flit [NUM_IN];
  int                rr_vc;
  logic [NUM_IN-1:0] ready_bits;
  logic              eject_mode;

  function automatic void move_waiting(int p);
    int v;
    v = int'(port_flit[p].vc);
    if (v < NUM_VC && !vc_full[v]) begin
      vc_flit[v] = port_flit[p];
      vc_full[v] = 1'b1;
      port_full[p] = 1'b0;
      ready_bits[p] = 1'b1;
    end else begin
      ready_bits[p] = 1'b0;
    end
  endfunction

  function automatic out_item_t port_step(in_item_t it);
    out_item_t  res;
    held_flit_t f;
    res = '0;
    if (it.action == ACT_TICK) begin
      rr_vc = (rr_vc + 1) % NUM_VC;
      if (vc_full[rr_vc]) begin
        f = vc_flit[rr_vc];
        if (eject_mode || (f.vc < CREDIT_BITS && it.credit_free[f.vc])) begin
          res.out_valid = 1'b1;
          res.out_vc = f.vc;
          res.out_kind = f.kind;
          res.out_data = f.data;
          vc_full[rr_vc] = 1'b0;
        end
      end
      for (int p = 0; p < NUM_IN; p++)
        if (port_full[p])
          move_waiting(p);
    end else if (it.in_port < NUM_IN && it.flit_vc < NUM_VC) begin
      port_flit[it.in_port].vc = it.flit_vc;
      port_flit[it.in_port].kind = it.flit_kind;
      port_flit[it.in_port].data = it.flit_data;
      port_full[it.in_port] = 1'b1;
      move_waiting(it.in_port);
    end
    res.ready_mask = ready_bits;
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      vc_full = '0;
      port_full = '0;
      rr_vc = 0;
      ready_bits = '1;
      eject_mode = 1'b0;
      src_gap = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_LOCAL_MODE)
        eject_mode = pwdata[0];
      if (s_tvalid && s_tready)
        egress_expect.push_back(port_step(cur_item));
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          src_gap = src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (port_items.size() != 0) begin
          cur_item = port_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {5'b0, cur_item.credit_free, cur_item.flit_data, cur_item.flit_kind,
                      cur_item.flit_vc, cur_item.in_port};
          s_tuser <= cur_item.action;
          if (idle_on && $urandom_range(0, 7) == 0)
            src_gap = $urandom_range(1, 19);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // monitor and watchdog
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (egress_expect.size() == 0) begin
          $error("result item with none expected: tuser %0h tdata %0h", m_tuser, m_tdata);
          err_cnt++;
        end else begin
          want = egress_expect.pop_front();
          check_field("out_valid", want.out_valid, m_tuser[0]);
          check_field("out_vc", want.out_vc, m_tdata[1:0]);
          check_field("out_kind", want.out_kind, m_tdata[3:2]);
          check_field("out_data", want.out_data, m_tdata[35:4]);
          check_field("ready_mask", want.ready_mask, m_tdata[40:36]);
        end
      end
      if (sink_stall != 0) begin
        sink_stall = sink_stall - 1;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_stall = $urandom_range(0, 18);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic push_item(logic act, int port, int vc, int kind, logic [31:0] data,
                           logic [3:0] credit);
    in_item_t it;
    it.action = act;
    it.in_port = PORT_BITS'(port);
    it.flit_vc = VC_BITS'(vc);
    it.flit_kind = KIND_BITS'(kind);
    it.flit_data = data;
    it.credit_free = credit;
    port_items.push_back(it);
  endtask

  task automatic push_random(int arrive_pct);
    logic [31:0] data;
    logic [3:0]  credit;
    int          port;
    case ($urandom_range(0, 7))
      0:       data = '0;
      1:       data = '1;
      default: data = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       credit = 4'h0;
      1:       credit = 4'hf;
      default: credit = 4'($urandom_range(0, 15));
    endcase
    port = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_IN, 7) : $urandom_range(0, NUM_IN - 1);
    push_item(($urandom_range(0, 99) < arrive_pct) ? ACT_ARRIVE : ACT_TICK, port,
              $urandom_range(0, 3), $urandom_range(0, 3), data, credit);
  endtask

  task automatic wait_idle();
    while (port_items.size() != 0 || s_tvalid || egress_expect.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(logic val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_LOCAL_MODE;
    pwdata <= {31'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int arrive_pct [8];
    arrive_pct = '{50, 70, 30, 50, 80, 50, 20, 50};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    // credit checked departures, blocked ports and overwrites
    push_item(ACT_TICK,   0, 0, 0, 32'h0,        4'hf);
    push_item(ACT_ARRIVE, 0, 0, 0, 32'h0,        4'h0);
    push_item(ACT_ARRIVE, 1, 0, 1, 32'hffffffff, 4'hf);
    push_item(ACT_ARRIVE, 1, 0, 2, 32'ha5a5a5a5, 4'h0);
    push_item(ACT_ARRIVE, 4, 3, 3, 32'hffffffff, 4'hf);
    push_item(ACT_ARRIVE, 5, 1, 0, 32'h12345678, 4'hf);
    push_item(ACT_ARRIVE, 7, 2, 3, 32'hffffffff, 4'hf);
    push_item(ACT_ARRIVE, 2, 1, 2, 32'h5a5a5a5a, 4'h0);
    push_item(ACT_ARRIVE, 3, 2, 1, 32'h00000001, 4'h0);
    push_item(ACT_ARRIVE, 2, 3, 0, 32'h80000000, 4'h0);
    for (int i = 0; i < 4; i++)
      push_item(ACT_TICK, 7, 3, 3, 32'hffffffff, 4'h0);
    push_item(ACT_TICK, 0, 0, 0, 32'h0, 4'h5);
    push_item(ACT_TICK, 0, 0, 0, 32'h0, 4'ha);
    for (int i = 0; i < 4; i++)
      push_item(ACT_TICK, 0, 0, 0, 32'h0, 4'hf);
    wait_idle();

    // ejection mode ignores credit
    write_mode(1'b1);
    push_item(ACT_ARRIVE, 0, 2, 3, 32'hdeadbeef, 4'h0);
    push_item(ACT_ARRIVE, 1, 2, 0, 32'h0badf00d, 4'h0);
    push_item(ACT_ARRIVE, 3, 0, 1, 32'h13579bdf, 4'h0);
    for (int i = 0; i < 4; i++)
      push_item(ACT_TICK, 0, 0, 0, 32'h0, 4'h0);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_mode(ph[0]);
      if (ph == 7)
        idle_on = 1'b0;
      for (int i = 0; i < 200; i++)
        push_random(arrive_pct[ph]);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (err_cnt == 0 && egress_expect.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
